/* sv/sbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the smoothed background subtract block.
// No dependencies.
package sbs_pkg;

  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int LINE_W     = 2 * RGB_W;   // two stored rows per column
  localparam int ROW_W      = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_HEIGHT = 1024;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [RGB_W-1:0]  rgb_t;     // red in the top byte
  typedef logic [2:0][CHAN_W-1:0] chans_t;   // [0] red, [1] green, [2] blue
  typedef logic [2:0][RGB_W-1:0]  column_t;  // [0] top, [1] middle, [2] bottom
  typedef column_t [2:0] window_t;            // [0] left, [1] centre, [2] right

  typedef struct packed {
    logic             valid;
    logic             done;
    logic [ROW_W-1:0] row;
  } ctl_t;

  typedef struct packed {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             done;
  } out_item_t;

endpackage

/* sv/sbs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sbs_line_window.sv */
`timescale 1ns / 1ps
// Position counters, two line RAMs (frame and background) and the 3x3 windows.
// Depends on sbs_pkg and sbs_ram.
module sbs_line_window import sbs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_accept,
  input  logic                                  sof,
  input  rgb_t                                  pix,
  input  rgb_t                                  bak,
  input  logic [((($clog2(MAX_WIDTH) + 1) > CFG_W) ?
                 ($clog2(MAX_WIDTH) + 1) : CFG_W) - 1:0] width,
  input  logic [CFG_W-1:0]                      height,
  output logic                                  s1_valid,
  output logic [ROW_W-1:0]                      s1_row,
  output logic [$clog2(MAX_WIDTH)-1:0]          s1_col,
  output window_t                               fwin,
  output window_t                               bwin
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int WEW  = ((COLW + 1) > CFG_W) ? (COLW + 1) : CFG_W;

  logic [ROW_W-1:0] row_count, row_count_next, r_cur;
  logic [COLW-1:0]  col_count, col_count_next, c_cur;
  logic             col_last, row_last;

  rgb_t             s1_pix, s1_bak;
  logic             fwd;
  logic [LINE_W-1:0] fwd_f, fwd_b;
  logic [LINE_W-1:0] f_rdata, b_rdata, f_line, b_line, f_wdata, b_wdata;
  column_t          f_left, f_mid, f_cur, b_left, b_mid, b_cur;

  always_comb begin
    r_cur    = sof ? '0 : row_count;
    c_cur    = sof ? '0 : col_count;
    col_last = (WEW'(c_cur) + WEW'(1)) >= width;
    row_last = (CFG_W'(r_cur) + CFG_W'(1)) >= height;
    row_count_next = r_cur;
    col_count_next = c_cur + COLW'(1);
    if (col_last) begin
      col_count_next = '0;
      row_count_next = row_last ? '0 : r_cur + ROW_W'(1);
    end
  end

  sbs_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_frame_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (f_wdata),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (f_rdata)
  );

  sbs_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_back_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (b_wdata),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (b_rdata)
  );

  // Back-to-back requests on the same column (width of one) take the
  // write data of the previous request instead of the stale RAM word.
  always_comb begin
    f_line  = fwd ? fwd_f : f_rdata;
    b_line  = fwd ? fwd_b : b_rdata;
    f_cur   = {s1_pix, f_line[RGB_W-1:0], f_line[LINE_W-1:RGB_W]};
    b_cur   = {s1_bak, b_line[RGB_W-1:0], b_line[LINE_W-1:RGB_W]};
    f_wdata = {f_line[RGB_W-1:0], s1_pix};
    b_wdata = {b_line[RGB_W-1:0], s1_bak};
    fwin    = {f_cur, f_mid, f_left};
    bwin    = {b_cur, b_mid, b_left};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
      fwd       <= 1'b0;
      f_left    <= '0;
      f_mid     <= '0;
      b_left    <= '0;
      b_mid     <= '0;
    end else begin
      s1_valid <= in_accept;
      if (in_accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
        fwd       <= s1_valid && (s1_col == c_cur);
      end
      if (s1_valid) begin
        f_left <= f_mid;
        f_mid  <= f_cur;
        b_left <= b_mid;
        b_mid  <= b_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row <= r_cur;
      s1_col <= c_cur;
      s1_pix <= pix;
      s1_bak <= bak;
      fwd_f  <= f_wdata;
      fwd_b  <= b_wdata;
    end
  end

endmodule

/* sv/sbs_smooth.sv */
`timescale 1ns / 1ps
// 3x3 weighted smoothing of one RGB window, divide by constant, three stages.
// Depends on sbs_pkg.
module sbs_smooth import sbs_pkg::*; #(
  parameter int CENTER_WEIGHT = 20
) (
  input  logic    clk,
  input  window_t win,
  input  logic    raw,
  output chans_t  smoothed
);

  localparam int DIV    = CENTER_WEIGHT + 12;
  localparam int SUM_W  = $clog2(255 * DIV + 1);
  localparam int K      = SUM_W;
  localparam int RECIP  = (1 << K) / DIV;
  localparam int PROD_W = SUM_W + K;

  logic [SUM_W-1:0]  sum_n [3];
  logic [SUM_W-1:0]  sum_a [3];
  logic [SUM_W-1:0]  sum_b [3];
  logic [PROD_W-1:0] prod_b [3];
  chan_t             ctr_a [3];
  chan_t             ctr_b [3];
  logic              raw_a, raw_b;
  chan_t             q0 [3];
  chan_t             quot [3];
  logic [SUM_W-1:0]  rem [3];

  function automatic logic [SUM_W-1:0] px(rgb_t p, int k);
    return SUM_W'(p[(2 - k) * CHAN_W +: CHAN_W]);
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_n[k] = px(win[0][0], k) + (px(win[1][0], k) << 1) + px(win[2][0], k)
               + (px(win[0][1], k) << 1)
               + SUM_W'(CENTER_WEIGHT) * px(win[1][1], k)
               + (px(win[2][1], k) << 1)
               + px(win[0][2], k) + (px(win[1][2], k) << 1) + px(win[2][2], k);
    end
  end

  // reciprocal estimate is at most one short; one compare fixes it
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q0[k]   = prod_b[k][K +: CHAN_W];
      rem[k]  = sum_b[k] - SUM_W'(q0[k]) * SUM_W'(DIV);
      quot[k] = q0[k] + CHAN_W'(rem[k] >= SUM_W'(DIV));
    end
  end

  always_ff @(posedge clk) begin
    raw_a <= raw;
    raw_b <= raw_a;
    for (int k = 0; k < 3; k++) begin
      sum_a[k]    <= sum_n[k];
      ctr_a[k]    <= win[1][1][(2 - k) * CHAN_W +: CHAN_W];
      sum_b[k]    <= sum_a[k];
      prod_b[k]   <= PROD_W'(sum_a[k]) * PROD_W'(RECIP);
      ctr_b[k]    <= ctr_a[k];
      smoothed[k] <= raw_b ? ctr_b[k] : quot[k];
    end
  end

endmodule

/* sv/sbs_out_queue.sv */
`timescale 1ns / 1ps
// Small register FIFO holding finished result items for the output channel.
// Depends on sbs_pkg.
module sbs_out_queue import sbs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  input  logic      pop,
  output out_item_t head,
  output logic      not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             full, do_pop;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && full |-> do_pop)
    else $error("result queue written while full");
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("result queue count lost a write");
`endif

endmodule

/* sv/smoothed_background_subtract_core.sv */
`timescale 1ns / 1ps
// Smoothed background subtraction: top level.
// Depends on sbs_pkg, sbs_line_window, sbs_smooth, sbs_out_queue.
//
// Usage:
//   Input channel (in_valid/in_ready): one frame pixel and the background
//   pixel at the same place per request, raster order; start_of_frame
//   marks row 0, column 0. Output channel (out_valid/out_ready): at most
//   one result per request, for the pixel one row up and one column left;
//   row 0 and column 0 of the input emit nothing, and frame_done flags the
//   last emitted pixel (h-2, w-2).
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//   frame width, 1 the frame height. Write only while the stream is idle;
//   no input request is taken in a cycle that carries a write.
//   Throughput: one request per cycle while a credit is free and no
//   configuration write is pending. Results reach out_valid through the
//   RAM read, the window adder tree and the two-step constant divide.
//   Stall: finished results wait in an 8-entry queue; input requests are
//   taken while fewer than 8 are in flight or queued, so a stalled
//   receiver holds off the sender after 8 requests that produce a result.
//   Reset: counters, windows, queue and credits clear at once; the line
//   RAMs need no clearing pass. Width and height return to 640 x 480.
module smoothed_background_subtract_core import sbs_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int CENTER_WEIGHT = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    pix_red,
  input  logic [CHAN_W-1:0]    pix_green,
  input  logic [CHAN_W-1:0]    pix_blue,
  input  logic [CHAN_W-1:0]    back_red,
  input  logic [CHAN_W-1:0]    back_green,
  input  logic [CHAN_W-1:0]    back_blue,
  input  logic                 start_of_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [ROW_W-1:0]     out_row,
  output logic [ROW_W-1:0]     out_col,
  output logic                 frame_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int COLW        = $clog2(MAX_WIDTH);
  localparam int WEW         = ((COLW + 1) > CFG_W) ? (COLW + 1) : CFG_W;
  localparam int XW          = (COLW > ROW_W) ? COLW : ROW_W;
  localparam int WIDTH_RESET = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int QUEUE_DEPTH = 8;
  localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);
  // right-hand mask from column 11w/13 on
  localparam int MASK_COL_NUM = 11;
  localparam int MASK_COL_DEN = 13;
  localparam int NUMW   = WEW + 4;
  localparam int K2     = NUMW;
  localparam int RECIP2 = (1 << K2) / MASK_COL_DEN;
  localparam int PRODW  = NUMW + K2;

  logic [WEW-1:0]   width;
  logic [CFG_W-1:0] height;
  logic [WEW-1:0]   width_in;
  logic [CFG_W-1:0] height_in;

  logic                in_accept, pop, drop;
  logic [CREDIT_W-1:0] credits, credits_next;

  logic                s1_valid;
  logic [ROW_W-1:0]    s1_row;
  logic [COLW-1:0]     s1_col;
  window_t             fwin, bwin;
  logic                s1_emit, s1_raw, s1_done;
  logic [ROW_W-1:0]    s1_y;
  logic [XW-1:0]       s1_x;

  ctl_t             ctl_s2, ctl_s3, ctl_s4;
  logic [XW-1:0]    x_s2, x_s3, x_s4;
  chans_t           fp, bp;

  logic [NUMW-1:0]  num_r, num_d, thr_x, q0_x, rem_x;
  logic [PRODW-1:0] prod_r;
  logic [CFG_W-1:0] h8, h78;
  logic [13:0]      h7;

  logic             bg, masked;
  out_item_t        item, head;

  assign cfg_ready = 1'b1;
  assign in_ready  = (credits < CREDIT_W'(QUEUE_DEPTH)) && !cfg_valid;
  assign in_accept = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // sizes are held clamped to the supported range
  always_comb begin
    if (cfg_data == '0) begin
      width_in = WEW'(1);
    end else if (WEW'(cfg_data) > WEW'(MAX_WIDTH)) begin
      width_in = WEW'(MAX_WIDTH);
    end else begin
      width_in = WEW'(cfg_data);
    end
    if (cfg_data == '0) begin
      height_in = CFG_W'(1);
    end else if (cfg_data > CFG_W'(MAX_HEIGHT)) begin
      height_in = CFG_W'(MAX_HEIGHT);
    end else begin
      height_in = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WEW'(WIDTH_RESET);
      height <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width  <= width_in;
        CFG_FRAME_HEIGHT: height <= height_in;
        default: ;
      endcase
    end
  end

  // mask thresholds, refreshed every cycle; settled well before a request
  // reaches the final stage
  always_comb begin
    q0_x  = prod_r[K2 +: NUMW];
    rem_x = num_d - q0_x * NUMW'(MASK_COL_DEN);
    h7    = 14'(height) * 14'd7;
  end

  always_ff @(posedge clk) begin
    num_r  <= NUMW'(width) * NUMW'(MASK_COL_NUM);
    num_d  <= num_r;
    prod_r <= PRODW'(num_r) * PRODW'(RECIP2);
    thr_x  <= q0_x + NUMW'(rem_x >= NUMW'(MASK_COL_DEN));
    h8     <= height >> 3;
    h78    <= h7[13:3];
  end

  sbs_line_window #(.MAX_WIDTH(MAX_WIDTH)) u_line_window (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .sof       (start_of_frame),
    .pix       ({pix_red, pix_green, pix_blue}),
    .bak       ({back_red, back_green, back_blue}),
    .width     (width),
    .height    (height),
    .s1_valid  (s1_valid),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .fwin      (fwin),
    .bwin      (bwin)
  );

  always_comb begin
    s1_emit = (s1_row != '0) && (s1_col != '0);
    s1_raw  = (s1_row == ROW_W'(1)) || (s1_col == COLW'(1))
           || (CFG_W'(s1_row) >= height) || (WEW'(s1_col) >= width);
    s1_done = ((CFG_W'(s1_row) + CFG_W'(1)) == height)
           && ((WEW'(s1_col) + WEW'(1)) == width);
    s1_y    = s1_row - ROW_W'(1);
    s1_x    = XW'(s1_col) - XW'(1);
  end

  sbs_smooth #(.CENTER_WEIGHT(CENTER_WEIGHT)) u_smooth_frame (
    .clk      (clk),
    .win      (fwin),
    .raw      (s1_raw),
    .smoothed (fp)
  );

  sbs_smooth #(.CENTER_WEIGHT(CENTER_WEIGHT)) u_smooth_back (
    .clk      (clk),
    .win      (bwin),
    .raw      (s1_raw),
    .smoothed (bp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s2.valid <= 1'b0;
      ctl_s3.valid <= 1'b0;
      ctl_s4.valid <= 1'b0;
    end else begin
      ctl_s2.valid <= s1_valid && s1_emit;
      ctl_s3.valid <= ctl_s2.valid;
      ctl_s4.valid <= ctl_s3.valid;
    end
    ctl_s2.done <= s1_done;
    ctl_s2.row  <= s1_y;
    x_s2        <= s1_x;
    ctl_s3.done <= ctl_s2.done;
    ctl_s3.row  <= ctl_s2.row;
    x_s3        <= x_s2;
    ctl_s4.done <= ctl_s3.done;
    ctl_s4.row  <= ctl_s3.row;
    x_s4        <= x_s3;
  end

  // background when every channel sits strictly inside 0.75b..1.25b
  always_comb begin
    bg = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!(((11'(bp[k]) * 11'd3) < (11'(fp[k]) << 2))
            && ((11'(fp[k]) << 2) < (11'(bp[k]) * 11'd5)))) begin
        bg = 1'b0;
      end
    end
    masked = (CFG_W'(ctl_s4.row) < h8) || (CFG_W'(ctl_s4.row) >= h78)
          || (NUMW'(x_s4) >= thr_x);
    item.red   = (bg || masked) ? '0 : fp[0];
    item.green = (bg || masked) ? '0 : fp[1];
    item.blue  = (bg || masked) ? '0 : fp[2];
    item.row   = ctl_s4.row;
    item.col   = x_s4[ROW_W-1:0];
    item.done  = ctl_s4.done;
  end

  sbs_out_queue #(.DEPTH(QUEUE_DEPTH)) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl_s4.valid),
    .push_data (item),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid)
  );

  assign out_red    = head.red;
  assign out_green  = head.green;
  assign out_blue   = head.blue;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign frame_done = head.done;

  // a credit lives from the input request until its result leaves, or until
  // the request is found to emit nothing
  assign drop = s1_valid && !s1_emit;

  always_comb begin
    credits_next = credits + CREDIT_W'(in_accept) - CREDIT_W'(pop) - CREDIT_W'(drop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= CREDIT_W'(QUEUE_DEPTH))
    else $error("more requests in flight than queue slots");
  a_result_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credits != '0)
    else $error("result pending without a credit");
  a_request_reaches_window: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted request missing from window stage");
`endif

endmodule
